### sv/sfs_pkg.sv
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int DUR_W          = 16;
  localparam int STEP_W         = 16;
  localparam int ENTRY_W        = 4;
  localparam int POS_W          = 24;
  localparam int FRAME_W        = 4;
  localparam int PMODE_W        = 2;
  localparam int FCOUNT_W       = 5;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 32;

  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;

  typedef enum logic [1:0] {
    ITEM_ADVANCE = 2'd0,
    ITEM_WRITE   = 2'd1,
    ITEM_RESET   = 2'd2
  } item_mode_t;

  typedef enum logic [1:0] {
    PLAY_CLAMP = 2'd0,
    PLAY_LOOP  = 2'd1,
    PLAY_PONG  = 2'd2
  } play_mode_t;

  localparam logic REG_PLAY_MODE   = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

endpackage

### sv/sfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sfs_ram #(
  parameter int WIDTH = sfs_pkg::DUR_W,
  parameter int DEPTH = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: control, arithmetic and table sweeps.
//
//  Channel   Direction  Handshake                     Contents
//  s_*       in         s_tvalid / s_tready           tuser mode, tdata step/index/duration
//  m_*       out        m_tvalid / m_tready           tdata frame, position, reversing
//  apb       in/out     psel & penable & pwrite       play_mode at 0x0, frame_count at 0x4
//
// An advance over n active frames makes a pass over the duration RAM that sums the active
// entries, folds the position in ST_CALC, makes a second pass over the table that searches
// for the frame and may stop early, and loads the result in ST_FIN. Other items go straight
// to ST_FIN. One item is in work at a time; a finished result waits in the output register
// while the next item is accepted. Reset clears the entry valid bits at once, so no
// clearing pass is needed. A stalled output holds back only the end of the next item.
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // mode [1:0]
  input  logic [1:0]                      s_tuser,
  // step_frames [15:0], entry_index [19:16], entry_duration [35:20], zero [39:36]
  input  logic [sfs_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // frame_index [3:0], position [27:4], reversing [28], zero [31:29]
  output logic [sfs_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfs_pkg::APB_AW-1:0]      paddr,
  input  logic [sfs_pkg::APB_DW-1:0]      pwdata,
  output logic [sfs_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int TOTAL_W = sfs_pkg::DUR_W + CNT_W;
  localparam int CW      = ((TOTAL_W > sfs_pkg::POS_W) ? TOTAL_W : sfs_pkg::POS_W) + 3;
  localparam int CMP_W   = ((CNT_W > sfs_pkg::FCOUNT_W) ? CNT_W : sfs_pkg::FCOUNT_W) + 1;

  localparam logic signed [CW-1:0] SAT_HI = CW'(sfs_pkg::POS_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(sfs_pkg::POS_MIN);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_CALC = 5'b00100,
    ST_SRCH = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                              state;
  logic [sfs_pkg::PMODE_W-1:0]         play_mode;
  logic [sfs_pkg::FCOUNT_W-1:0]        frame_count;
  logic [MAX_FRAMES-1:0]               valid;
  logic [CNT_W-1:0]                    cnt;
  logic [CNT_W-1:0]                    n_act;
  logic                                rd_pend;
  logic                                rd_ok;
  logic [IDX_W-1:0]                    rd_idx;
  logic [TOTAL_W-1:0]                  total;
  logic [TOTAL_W-1:0]                  lo;
  logic [sfs_pkg::STEP_W-1:0]          step_r;
  logic signed [sfs_pkg::POS_W-1:0]    pos;
  logic                                backward;
  logic [sfs_pkg::FRAME_W-1:0]         shown;

  logic                                accept;
  logic                                cfg_wr;
  logic                                out_load;
  logic [1:0]                          item_mode;
  logic [sfs_pkg::STEP_W-1:0]          in_step;
  logic [sfs_pkg::ENTRY_W-1:0]         in_index;
  logic [sfs_pkg::DUR_W-1:0]           in_dur;
  logic                                ram_we;
  logic [IDX_W-1:0]                    ram_waddr;
  logic [IDX_W-1:0]                    ram_raddr;
  logic [sfs_pkg::DUR_W-1:0]           ram_rdata;
  logic [sfs_pkg::DUR_W-1:0]           dur;
  logic                                issue;
  logic [CNT_W-1:0]                    n_sel;
  logic [TOTAL_W-1:0]                  hi;
  logic signed [CW-1:0]                p_ext;
  logic signed [CW-1:0]                s_ext;
  logic signed [CW-1:0]                t_ext;
  logic signed [CW-1:0]                lo_ext;
  logic signed [CW-1:0]                hi_ext;
  logic signed [CW-1:0]                fwd;
  logic signed [CW-1:0]                bwd;
  logic signed [CW-1:0]                np;
  logic                                nb;
  logic [sfs_pkg::POS_W-1:0]           pos_sat;
  logic                                hit;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign item_mode = s_tuser;
  assign in_step   = s_tdata[15:0];
  assign in_index  = s_tdata[19:16];
  assign in_dur    = s_tdata[35:20];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      sfs_pkg::REG_PLAY_MODE:   prdata = sfs_pkg::APB_DW'(play_mode);
      sfs_pkg::REG_FRAME_COUNT: prdata = sfs_pkg::APB_DW'(frame_count);
      default:                  prdata = '0;
    endcase
  end

  assign ram_we    = accept && (item_mode == sfs_pkg::ITEM_WRITE)
                     && (32'(in_index) < MAX_FRAMES);
  assign ram_waddr = IDX_W'(in_index);
  assign ram_raddr = cnt[IDX_W-1:0];
  assign issue     = (cnt < n_act);

  sfs_ram #(
    .WIDTH (sfs_pkg::DUR_W),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_dur),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign dur = rd_ok ? ram_rdata : '0;

  always_comb begin
    if (CMP_W'(frame_count) > CMP_W'(MAX_FRAMES)) begin
      n_sel = CNT_W'(MAX_FRAMES);
    end else begin
      n_sel = CNT_W'(frame_count);
    end
  end

  assign p_ext = CW'(pos);
  assign s_ext = signed'(CW'(step_r));
  assign t_ext = signed'(CW'(total));
  assign fwd   = p_ext + s_ext;
  assign bwd   = p_ext - s_ext;

  always_comb begin
    np = p_ext;
    nb = backward;
    unique case (play_mode)
      sfs_pkg::PLAY_CLAMP: begin
        np = (fwd > t_ext) ? t_ext : fwd;
      end
      sfs_pkg::PLAY_LOOP: begin
        np = (fwd > t_ext) ? (fwd - t_ext) : fwd;
      end
      sfs_pkg::PLAY_PONG: begin
        if (backward) begin
          if (bwd < 0) begin
            nb = 1'b0;
            np = -bwd;
          end else begin
            np = bwd;
          end
        end else if (fwd > t_ext) begin
          nb = 1'b1;
          np = (t_ext <<< 1) - fwd;
        end else begin
          np = fwd;
        end
      end
      default: begin
        np = p_ext;
      end
    endcase
  end

  always_comb begin
    priority if (np > SAT_HI) begin
      pos_sat = sfs_pkg::POS_W'(SAT_HI);
    end else if (np < SAT_LO) begin
      pos_sat = sfs_pkg::POS_W'(SAT_LO);
    end else begin
      pos_sat = sfs_pkg::POS_W'(np);
    end
  end

  assign hi     = lo + TOTAL_W'(dur);
  assign lo_ext = signed'(CW'(lo));
  assign hi_ext = signed'(CW'(hi));
  assign hit    = rd_pend && (p_ext > lo_ext) && (p_ext <= hi_ext);

  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      play_mode   <= '0;
      frame_count <= sfs_pkg::FCOUNT_W'(1);
      valid       <= '0;
      cnt         <= '0;
      n_act       <= '0;
      rd_pend     <= 1'b0;
      pos         <= '0;
      backward    <= 1'b0;
      shown       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          sfs_pkg::REG_PLAY_MODE:   play_mode   <= pwdata[sfs_pkg::PMODE_W-1:0];
          sfs_pkg::REG_FRAME_COUNT: frame_count <= pwdata[sfs_pkg::FCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if ((state == ST_SUM) || (state == ST_SRCH)) begin
        rd_pend <= issue;
        rd_idx  <= ram_raddr;
        rd_ok   <= issue && valid[ram_raddr];
        if (issue) begin
          cnt <= cnt + 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item_mode)
              sfs_pkg::ITEM_ADVANCE: begin
                total   <= '0;
                cnt     <= '0;
                rd_pend <= 1'b0;
                step_r  <= in_step;
                n_act   <= n_sel;
                state   <= ST_SUM;
              end
              sfs_pkg::ITEM_RESET: begin
                pos      <= '0;
                backward <= 1'b0;
                shown    <= '0;
                state    <= ST_FIN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_SUM: begin
          if (rd_pend) begin
            total <= total + TOTAL_W'(dur);
          end
          if (!issue && !rd_pend) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          pos      <= pos_sat;
          backward <= nb;
          cnt      <= '0;
          lo       <= '0;
          rd_pend  <= 1'b0;
          state    <= ST_SRCH;
        end
        ST_SRCH: begin
          if (hit) begin
            shown <= sfs_pkg::FRAME_W'(rd_idx);
            state <= ST_FIN;
          end else if (rd_pend) begin
            lo <= hi;
          end else if (!issue) begin
            shown <= '0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, backward, pos, shown};
    end
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_IDLE))
    else $error("duration RAM written while an item is in work");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SUM) || (state == ST_SRCH)) |-> (cnt <= n_act))
    else $error("table sweep ran past the active frames");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken result");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item accepted before the first finished");

endmodule

### bench/sprite_frame_sequencer_test.sv
// Self-checking testbench for the sprite frame sequencer, with a predicting scoreboard.
module sprite_frame_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int SETTLE       = 50;
  localparam int PRINT_CAP    = 50;

  localparam logic [1:0] ITEM_UNUSED = 2'd3;
  localparam logic [1:0] PLAY_UNUSED = 2'd3;

  typedef struct {
    logic [sfs_pkg::FRAME_W-1:0] frame;
    logic [sfs_pkg::POS_W-1:0]   position;
    logic                        reversing;
  } shown_state_t;

  class frame_scoreboard;
    logic [sfs_pkg::DUR_W-1:0]        durations [sfs_pkg::MAX_FRAMES_DEF];
    logic signed [sfs_pkg::POS_W-1:0] position;
    logic                             backward;
    logic [sfs_pkg::FRAME_W-1:0]      frame;
    logic [sfs_pkg::PMODE_W-1:0]      play_mode;
    logic [sfs_pkg::FCOUNT_W-1:0]     frame_count;
    shown_state_t                     shown_q[$];
    int errors, checked, advances, writes, resets, unused, saturations;

    function new();
      foreach (durations[i]) durations[i] = '0;
      position    = '0;
      backward    = 1'b0;
      frame       = '0;
      play_mode   = sfs_pkg::PLAY_CLAMP;
      frame_count = 5'd1;
    endfunction

    function void set_register(logic idx, logic [sfs_pkg::APB_DW-1:0] value);
      if (idx == sfs_pkg::REG_PLAY_MODE) play_mode = value[sfs_pkg::PMODE_W-1:0];
      else frame_count = value[sfs_pkg::FCOUNT_W-1:0];
    endfunction

    function int pending();
      return shown_q.size();
    endfunction

    function void advance(logic [sfs_pkg::STEP_W-1:0] step);
      longint total, pos, lo, hi, st;
      int n, i;
      logic [sfs_pkg::FRAME_W-1:0] hit;
      logic found;
      n = (frame_count > sfs_pkg::MAX_FRAMES_DEF) ? sfs_pkg::MAX_FRAMES_DEF
                                                   : int'(frame_count);
      st = longint'(step);
      total = 0;
      for (i = 0; i < n; i++) total += longint'(durations[i]);
      pos = longint'(position);
      case (play_mode)
        sfs_pkg::PLAY_CLAMP: begin
          pos += st;
          if (pos > total) pos = total;
        end
        sfs_pkg::PLAY_LOOP: begin
          pos += st;
          if (pos > total) pos -= total;
        end
        sfs_pkg::PLAY_PONG: begin
          if (backward) begin
            pos -= st;
            if (pos < 0) begin
              backward = 1'b0;
              pos = -pos;
            end
          end else begin
            pos += st;
            if (pos > total) begin
              backward = 1'b1;
              pos = 2 * total - pos;
            end
          end
        end
        default: ;
      endcase
      if (pos > sfs_pkg::POS_MAX) begin
        pos = sfs_pkg::POS_MAX;
        saturations++;
      end else if (pos < sfs_pkg::POS_MIN) begin
        pos = sfs_pkg::POS_MIN;
        saturations++;
      end
      position = pos[sfs_pkg::POS_W-1:0];
      hit = '0;
      found = 1'b0;
      lo = 0;
      for (i = 0; i < n; i++) begin
        hi = lo + longint'(durations[i]);
        if (!found && pos > lo && pos <= hi) begin
          hit = i[sfs_pkg::FRAME_W-1:0];
          found = 1'b1;
        end
        lo = hi;
      end
      frame = hit;
    endfunction

    function void note_input(logic [1:0] mode, logic [sfs_pkg::IN_DATA_W-1:0] data);
      shown_state_t s;
      case (mode)
        sfs_pkg::ITEM_ADVANCE: begin
          advance(data[15:0]);
          advances++;
        end
        sfs_pkg::ITEM_WRITE: begin
          durations[data[19:16]] = data[35:20];
          writes++;
        end
        sfs_pkg::ITEM_RESET: begin
          position = '0;
          backward = 1'b0;
          frame    = '0;
          resets++;
        end
        default: unused++;
      endcase
      s.frame     = frame;
      s.position  = position;
      s.reversing = backward;
      shown_q.push_back(s);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(logic [sfs_pkg::OUT_DATA_W-1:0] word);
      shown_state_t want;
      if (shown_q.size() == 0) begin
        report("result transfer with nothing pending", longint'(word), 0);
      end else begin
        want = shown_q.pop_front();
        checked++;
        if (word[3:0] !== want.frame) report("frame_index", word[3:0], want.frame);
        if (word[27:4] !== want.position)
          report("position", $signed(word[27:4]), $signed(want.position));
        if (word[28] !== want.reversing) report("reversing", word[28], want.reversing);
      end
    endtask

    task finish_check();
      if (shown_q.size() != 0) report("results never delivered", shown_q.size(), 0);
    endtask
  endclass

  logic                           clk;
  logic                           rst;
  logic [1:0]                     s_tuser;
  logic [sfs_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [sfs_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sfs_pkg::APB_AW-1:0]     paddr;
  logic [sfs_pkg::APB_DW-1:0]     pwdata;
  logic [sfs_pkg::APB_DW-1:0]     prdata;
  logic                           pready;

  frame_scoreboard sb = new();

  int gap_max      = 0;
  int burst_max    = 8;
  int burst_left   = 0;
  int stall_pct    = 0;
  int stall_max    = 0;
  int hold_off_req = 0;
  int hold_offs    = 0;
  int settings     = 0;

  sprite_frame_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles.", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 0;
        hold_offs++;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, stall_max);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [sfs_pkg::IN_DATA_W-1:0] item_word(logic [15:0] step,
                                                              logic [3:0] idx,
                                                              logic [15:0] dur);
    return {4'b0000, dur, idx, step};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(logic [1:0] mode, logic [sfs_pkg::IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tuser  <= mode;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic apb_write(logic idx, logic [sfs_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(logic [1:0] play, logic [4:0] count);
    logic [sfs_pkg::APB_DW-1:0] noise;
    drain();
    noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    apb_write(sfs_pkg::REG_PLAY_MODE, {noise[sfs_pkg::APB_DW-1:2], play});
    noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    apb_write(sfs_pkg::REG_FRAME_COUNT, {noise[sfs_pkg::APB_DW-1:5], count});
    settings++;
  endtask

  task automatic run_directed();
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd0, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_WRITE,   item_word(16'hFFFF, 4'd0, 16'hFFFF));
    offer(sfs_pkg::ITEM_WRITE,   item_word(16'd0, 4'd15, 16'hFFFF));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'hF, 16'hFFFF));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd1, 4'd0, 16'd0));
    offer(ITEM_UNUSED,           item_word(16'hFFFF, 4'hF, 16'hFFFF));
    offer(sfs_pkg::ITEM_RESET,   item_word(16'hFFFF, 4'hF, 16'hFFFF));
    set_config(sfs_pkg::PLAY_LOOP, 5'd2);
    offer(sfs_pkg::ITEM_WRITE,   item_word(16'd0, 4'd0, 16'd2));
    offer(sfs_pkg::ITEM_WRITE,   item_word(16'd0, 4'd1, 16'd3));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd4, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'd0, 16'd0));
    set_config(sfs_pkg::PLAY_PONG, 5'd2);
    offer(sfs_pkg::ITEM_RESET,   item_word(16'd0, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd4, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd3, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd5, 4'd0, 16'd0));
    set_config(sfs_pkg::PLAY_CLAMP, 5'd0);
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd7, 4'd0, 16'd0));
    set_config(PLAY_UNUSED, 5'd31);
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'd9, 4'd0, 16'd0));
    set_config(sfs_pkg::PLAY_CLAMP, 5'd16);
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'd0, 16'd0));
  endtask

  // Loop overshoot piles up until the position saturates, then ping-pong folds it
  // past both ends of the signed range.
  task automatic run_drift();
    set_config(sfs_pkg::PLAY_LOOP, 5'd2);
    offer(sfs_pkg::ITEM_RESET, item_word(16'd0, 4'd0, 16'd0));
    offer(sfs_pkg::ITEM_WRITE, item_word(16'($urandom), 4'd0, 16'd2));
    offer(sfs_pkg::ITEM_WRITE, item_word(16'($urandom), 4'd1, 16'd3));
    repeat (140)
      offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'($urandom), 16'($urandom)));
    set_config(sfs_pkg::PLAY_PONG, 5'd2);
    repeat (4)
      offer(sfs_pkg::ITEM_ADVANCE, item_word(16'hFFFF, 4'($urandom), 16'($urandom)));
  endtask

  task automatic random_item(int n_act, int scale);
    int r, lim;
    logic [15:0] step, dur;
    logic [3:0]  idx;
    r    = $urandom_range(0, 99);
    step = 16'($urandom);
    idx  = 4'($urandom);
    dur  = 16'($urandom);
    lim  = (2 * scale > 65535) ? 65535 : 2 * scale;
    if (r < 62) begin
      case ($urandom_range(0, 9))
        0: step = 16'd0;
        1: step = 16'hFFFF;
        2: ;
        default: step = 16'($urandom_range(0, lim));
      endcase
      offer(sfs_pkg::ITEM_ADVANCE, item_word(step, idx, dur));
    end else if (r < 86) begin
      if (n_act > 0 && $urandom_range(0, 9) < 7) idx = 4'($urandom_range(0, n_act - 1));
      case ($urandom_range(0, 19))
        0: dur = 16'd0;
        1: dur = 16'hFFFF;
        2, 3: ;
        default: dur = 16'($urandom_range(0, scale));
      endcase
      offer(sfs_pkg::ITEM_WRITE, item_word(step, idx, dur));
    end else if (r < 94) begin
      offer(sfs_pkg::ITEM_RESET, item_word(step, idx, dur));
    end else begin
      offer(ITEM_UNUSED, item_word(step, idx, dur));
    end
  endtask

  task automatic run_phase(int ph);
    int n_act, scale, items, k, pick;
    logic [1:0] play;
    logic [4:0] count;
    play = ph[1:0];
    case (ph % 6)
      0: count = 5'd1;
      1: count = 5'd16;
      2: count = (ph < 6) ? 5'd0 : 5'($urandom_range(1, 16));
      3: count = 5'($urandom_range(17, 31));
      default: count = 5'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 2))
      0: gap_max = 0;
      1: gap_max = 2;
      default: gap_max = 10;
    endcase
    burst_max = $urandom_range(1, 24);
    case ($urandom_range(0, 3))
      0: stall_pct = 0;
      1: stall_pct = 20;
      2: stall_pct = 50;
      default: stall_pct = 85;
    endcase
    stall_max = $urandom_range(0, 8);
    set_config(play, count);
    if (ph == 2) begin
      gap_max = 0;
      hold_off_req = 1;
    end
    n_act = (count > sfs_pkg::MAX_FRAMES_DEF) ? sfs_pkg::MAX_FRAMES_DEF : int'(count);
    pick = $urandom_range(0, 9);
    scale = (pick < 6) ? $urandom_range(1, 20) : (pick < 9) ? 500 : 65535;
    if ($urandom_range(0, 1) == 0)
      offer(sfs_pkg::ITEM_RESET, item_word(16'($urandom), 4'($urandom), 16'($urandom)));
    for (k = 0; k < n_act; k++) begin
      if ($urandom_range(0, 4) != 0)
        offer(sfs_pkg::ITEM_WRITE,
              item_word(16'($urandom), k[3:0], 16'($urandom_range(1, scale))));
    end
    items = $urandom_range(85, 110);
    repeat (items) random_item(n_act, scale);
  endtask

  initial begin : stimulus
    int ph;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = '0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    run_drift();
    for (ph = 0; ph < PHASES; ph++) run_phase(ph);
    drain();
    repeat (SETTLE) @(negedge clk);
    sb.finish_check();
    $display("Checked %0d results from %0d advances, %0d entry writes, %0d position resets",
             sb.checked, sb.advances, sb.writes, sb.resets);
    $display("and %0d unused-mode items over %0d register settings; %0d saturations, %0d %s",
             sb.unused, settings, sb.saturations, hold_offs, "hold-offs.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sfs_pkg.sv
sv/sfs_ram.sv
sv/sprite_frame_sequencer.sv
bench/sprite_frame_sequencer_test.sv
